// ===== rtl/core/mde_pkg.sv =====
// Shared widths, reset values and controller/datapath handshake types for the determinant engine.
package mde_pkg;

	// Field widths of the item and configuration channels.
	localparam int ELEM_W = 12;
	localparam int DET_W  = 64;
	localparam int SIZE_W = 3;

	// Matrix size after reset.
	localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic acc_clr;   // start a new determinant: clear sum, seed the product stack
		logic mul_en;    // extend the partial product by the entry just read
		logic acc_en;    // add a finished permutation product into the sum
		logic acc_neg;   // subtract instead of add (odd permutation)
		logic out_load;  // move the sum into the output register
	} mde_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic out_full;  // output register still holds an item not yet taken
	} mde_stat_t;

endpackage

// ===== rtl/core/mde_channels.sv =====
// Valid/ready channel interfaces for matrix entries, determinants and the size register.

interface mde_elem_if;
	logic                              valid;
	logic                              ready;
	logic signed [mde_pkg::ELEM_W-1:0] element;

	modport source (output valid, output element, input ready);
	modport sink   (input valid, input element, output ready);
endinterface

interface mde_det_if;
	logic                             valid;
	logic                             ready;
	logic signed [mde_pkg::DET_W-1:0] det_value;

	modport source (output valid, output det_value, input ready);
	modport sink   (input valid, input det_value, output ready);
endinterface

interface mde_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [mde_pkg::SIZE_W-1:0] matrix_size;

	modport source (output valid, output matrix_size, input ready);
	modport sink   (input valid, input matrix_size, output ready);
endinterface

// ===== rtl/core/matrix_determinant_engine_top.sv =====
// Top level of the matrix determinant engine.
//
// Entries of an n x n matrix (n from the size register, 0 read as 1 and values above
// MAX_SIZE read as MAX_SIZE) arrive row-major on elem, one item per cycle. After the last
// entry the engine computes the exact determinant by cofactor expansion along the first
// row, carried out as a depth-first walk over column choices with one shared multiplier
// and a stack of partial products, and presents it on det. The walk tests one column per
// cycle and passes through a separate multiply state for each multiplication. No entry is
// accepted during the walk or while a finished determinant still waits for the output
// register. The size register takes a write only while entries are loading; a write
// discards a partly loaded matrix and starts loading afresh.
module matrix_determinant_engine_top #(
	parameter int MAX_SIZE = 4
) (
	input logic        clk,
	input logic        arst_n,
	mde_elem_if.sink   elem,
	mde_det_if.source  det,
	mde_cfg_if.sink    cfg
);

	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(MAX_SIZE + 1);

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      rd_addr;
	logic [CNT_W-1:0]   depth;
	mde_pkg::mde_cmd_t  cmd;
	mde_pkg::mde_stat_t stat;

	// Sequencer.
	mde_ctrl #(
		.MAX_SIZE (MAX_SIZE)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elem.valid),
		.in_ready  (elem.ready),
		.cfg_valid (cfg.valid),
		.cfg_ready (cfg.ready),
		.cfg_size  (cfg.matrix_size),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.depth     (depth),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Storage and arithmetic.
	mde_dpath #(
		.MAX_SIZE (MAX_SIZE)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.element   (elem.element),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.depth     (depth),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (det.valid),
		.out_ready (det.ready),
		.det_value (det.det_value)
	);

endmodule

// ===== rtl/core/mde_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mde_ram #(
	parameter int W     = 12,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/mde_dpath.sv =====
// Datapath: entry store, partial-product stack, multiplier, signed accumulator and output register.
module mde_dpath #(
	parameter int MAX_SIZE = 4,
	localparam int DEPTH   = MAX_SIZE * MAX_SIZE,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W   = $clog2(MAX_SIZE + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [mde_pkg::ELEM_W-1:0] element,
	input  logic                              wr_en,
	input  logic [AW-1:0]                     wr_addr,
	input  logic [AW-1:0]                     rd_addr,
	input  logic [CNT_W-1:0]                  depth,
	input  mde_pkg::mde_cmd_t                 cmd,
	output mde_pkg::mde_stat_t                stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mde_pkg::DET_W-1:0]  det_value
);

	// A product of d entries needs at most d entry widths.
	localparam int PROD_W = mde_pkg::ELEM_W * MAX_SIZE;

	logic signed [mde_pkg::ELEM_W-1:0]        rd_data;
	logic signed [PROD_W-1:0]                 prod_q [MAX_SIZE+1];
	logic signed [PROD_W-1:0]                 prod_cur;
	logic signed [PROD_W+mde_pkg::ELEM_W-1:0] mul_full;
	logic signed [mde_pkg::DET_W-1:0]         term;
	logic signed [mde_pkg::DET_W-1:0]         acc_q;
	logic signed [mde_pkg::DET_W-1:0]         det_q;
	logic                                     out_valid_q;

	// Entry store, written row-major while loading and read by the search.
	mde_ram #(
		.W     (mde_pkg::ELEM_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (element),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Partial product at the current depth, its extension and its sign-extended sum term.
	assign prod_cur = prod_q[depth];
	assign mul_full = prod_cur * rd_data;
	assign term     = {{(mde_pkg::DET_W - PROD_W){prod_cur[PROD_W-1]}}, prod_cur};

	// Product stack and determinant sum.
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			prod_q[0] <= PROD_W'(1);
			acc_q     <= '0;
		end
		if (cmd.mul_en) begin
			prod_q[depth + CNT_W'(1)] <= mul_full[PROD_W-1:0];
		end
		if (cmd.acc_en) begin
			acc_q <= cmd.acc_neg ? (acc_q - term) : (acc_q + term);
		end
		if (cmd.out_load) begin
			det_q <= acc_q;
		end
	end

	// Output register occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign det_value     = det_q;
	assign stat.out_full = out_valid_q;

endmodule

// ===== rtl/core/mde_ctrl.sv =====
// Controller: load counter, size register and the depth-first permutation search sequencer.
module mde_ctrl #(
	parameter int MAX_SIZE = 4,
	localparam int DEPTH   = MAX_SIZE * MAX_SIZE,
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W   = $clog2(MAX_SIZE + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mde_pkg::SIZE_W-1:0] cfg_size,
	output logic                       wr_en,
	output logic [AW-1:0]              wr_addr,
	output logic [AW-1:0]              rd_addr,
	output logic [CNT_W-1:0]           depth,
	output mde_pkg::mde_cmd_t          cmd,
	input  mde_pkg::mde_stat_t         stat
);

	// Wide enough for n*n and for a row*n+col product.
	localparam int LC_W = 2 * CNT_W;

	typedef enum logic [3:0] {
		ST_LOAD   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_MUL    = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t                     state_q;
	logic [mde_pkg::SIZE_W-1:0] size_q;
	logic [LC_W-1:0]            load_cnt_q;
	logic [CNT_W-1:0]           depth_q;
	logic [CNT_W-1:0]           col_q  [MAX_SIZE+1];
	logic [MAX_SIZE-1:0]        mask_q [MAX_SIZE+1];
	logic                       par_q  [MAX_SIZE+1];

	logic [CNT_W-1:0]    n;
	logic [LC_W-1:0]     nn;
	logic [LC_W-1:0]     addr_w;
	logic [CNT_W-1:0]    col;
	logic [MAX_SIZE-1:0] mask;
	logic [MAX_SIZE-1:0] sel;
	logic                used;
	logic                sgn;
	logic                leaf;
	logic                exhausted;
	logic                in_acc;
	logic                last;

	// Effective size: zero counts as one, large values saturate.
	always_comb begin
		if (size_q == '0) begin
			n = CNT_W'(1);
		end else if (size_q > mde_pkg::SIZE_W'(MAX_SIZE)) begin
			n = CNT_W'(MAX_SIZE);
		end else begin
			n = CNT_W'(size_q);
		end
	end

	assign nn = {{CNT_W{1'b0}}, n} * {{CNT_W{1'b0}}, n};

	// Column under trial at the current depth and what the search knows about it.
	assign col       = col_q[depth_q];
	assign mask      = mask_q[depth_q];
	assign sel       = MAX_SIZE'(1) << col;
	assign used      = |(mask & sel);
	assign sgn       = ^(~mask & (sel - MAX_SIZE'(1)));
	assign leaf      = (depth_q == n);
	assign exhausted = (col >= n);

	// Store addresses: row-major load position and (row, column) of the trial.
	assign addr_w  = {{CNT_W{1'b0}}, depth_q} * {{CNT_W{1'b0}}, n} + {{CNT_W{1'b0}}, col};
	assign rd_addr = addr_w[AW-1:0];
	assign wr_addr = load_cnt_q[AW-1:0];
	assign depth   = depth_q;

	// The size register is written only while loading, and a size write takes
	// precedence over an entry in the same cycle.
	assign in_ready  = (state_q == ST_LOAD) && !cfg_valid;
	assign cfg_ready = (state_q == ST_LOAD);
	assign in_acc    = in_valid && in_ready;
	assign wr_en     = in_acc;
	assign last      = (load_cnt_q == nn - LC_W'(1));

	// Datapath commands.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.acc_clr = in_acc && last;
			end
			ST_SEARCH: begin
				cmd.acc_en  = leaf;
				cmd.acc_neg = par_q[depth_q];
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = !stat.out_full;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Sequencer: load entries, then walk every column choice row by row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			size_q     <= mde_pkg::SIZE_RESET;
			load_cnt_q <= '0;
			depth_q    <= '0;
			for (int i = 0; i <= MAX_SIZE; i++) begin
				col_q[i]  <= '0;
				mask_q[i] <= '0;
				par_q[i]  <= 1'b0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q     <= cfg_size;
				load_cnt_q <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (last) begin
							load_cnt_q <= '0;
							depth_q    <= '0;
							col_q[0]   <= '0;
							mask_q[0]  <= '0;
							par_q[0]   <= 1'b0;
							state_q    <= ST_SEARCH;
						end else begin
							load_cnt_q <= load_cnt_q + LC_W'(1);
						end
					end
				end
				ST_SEARCH: begin
					if (leaf || exhausted) begin
						// Back up one row, or finish when the first row is used up.
						if (depth_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							depth_q                   <= depth_q - CNT_W'(1);
							col_q[depth_q - CNT_W'(1)] <= col_q[depth_q - CNT_W'(1)] + CNT_W'(1);
						end
					end else if (used) begin
						col_q[depth_q] <= col + CNT_W'(1);
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// The entry read last cycle extends the product; descend one row.
					mask_q[depth_q + CNT_W'(1)] <= mask | sel;
					par_q[depth_q + CNT_W'(1)]  <= par_q[depth_q] ^ sgn;
					col_q[depth_q + CNT_W'(1)]  <= '0;
					depth_q                     <= depth_q + CNT_W'(1);
					state_q                     <= ST_SEARCH;
				end
				ST_DONE: begin
					if (!stat.out_full) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule
